### hw/rtl/pcca_pkg.sv
package pcca_pkg;

    localparam int LANES      = 4;
    localparam int MAX_PIXELS = 4096;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);

    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int SUM_W      = PROD_W + $clog2(LANES);
    localparam int ACC_W      = 40;
    localparam int OUT_W      = 32;

    localparam int CNT_W      = 13;
    localparam int POS_W      = 12;
    localparam int LUSED_W    = 3;
    localparam int LN_W       = ($clog2(LANES + 1) > LUSED_W) ? $clog2(LANES + 1) : LUSED_W;

    localparam int IN_BITS    = 2 * LANES * SAMPLE_W + LUSED_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = POS_W + OUT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic signed [ACC_W:0]      t_acc_ext;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT = 1'b0,
        CFG_PIXEL_COUNT   = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [ADDR_W-1:0] idx;
        logic [POS_W-1:0]  pos;
        logic              first_grp;
        logic              final_grp;
        logic              last_pix;
    } t_item_ctl;

endpackage

### hw/rtl/pcca_ram.sv
module pcca_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### hw/rtl/pcca_lane.sv
module pcca_lane (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic            i_lane_on,
    input  pcca_pkg::t_sample i_sample,
    input  pcca_pkg::t_sample i_weight,
    output pcca_pkg::t_prod   o_product
);

    pcca_pkg::t_prod n_product;

    always_comb begin
        n_product = i_sample * i_weight;
        if (!i_lane_on) begin
            n_product = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_product <= n_product;
        end
    end

endmodule

### hw/rtl/pcca_merge.sv
module pcca_merge (
    input  logic            i_clk,
    input  logic            i_en,
    input  pcca_pkg::t_prod i_products [pcca_pkg::LANES],
    output pcca_pkg::t_sum  o_sum
);

    pcca_pkg::t_sum n_sum;

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < pcca_pkg::LANES; k++) begin
            n_sum = n_sum + pcca_pkg::t_sum'(i_products[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sum <= n_sum;
        end
    end

endmodule

### hw/rtl/pointwise_conv_channel_accumulator.sv
// Pointwise 1x1 convolution accumulator for one filter's output plane.
// Input stream (s_axis): one pixel's channel group per transfer, four Q8.8
// samples and weights plus a lane count; groups arrive pixel 0..N-1, then
// the next channel group. Output stream (m_axis): one transfer per pixel of
// the final channel group, pixel index and saturated Q16.16 sum; tlast marks
// the plane's last pixel. The config channel (i_cfg_*) sets channel_count
// (index 0) and pixel_count (index 1) and is always ready; write it idle.
// Throughput: one input transfer per cycle while m_axis is not stalled. The per-pixel sum
// lives in a 4096 x 40 single-write RAM; a read-modify-write spans three
// stages (multiply, lane merge, accumulate) with write-back forwarding, so
// a repeated pixel in consecutive cycles costs nothing.
// Path: each result passes the lane, merge and output registers to m_axis.
// Reset clears progress and the config (both counts to 1); RAM contents are
// not cleared, the first channel group overwrites them.
// When m_axis stalls, the output register holds and the pipeline fills; at
// most three items are held before s_axis_tready drops.
module pointwise_conv_channel_accumulator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // config write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pcca_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pcca_pkg::CNT_W-1:0]         i_cfg_data,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // sample_lane0..3, weight_lane0..3 (16b each), lanes_used (3b), zero pad
    input  logic [pcca_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // pixel_index (12b), accumulated_value (32b), zero pad
    output logic [pcca_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast
);

    localparam int LANES = pcca_pkg::LANES;
    localparam int SW    = pcca_pkg::SAMPLE_W;
    localparam int CNT_W = pcca_pkg::CNT_W;
    localparam int POS_W = pcca_pkg::POS_W;
    localparam int LN_W  = pcca_pkg::LN_W;
    localparam int ACC_W = pcca_pkg::ACC_W;
    localparam int OUT_W = pcca_pkg::OUT_W;
    localparam int AW    = pcca_pkg::ADDR_W;

    // config and progress
    logic [CNT_W-1:0] r_chan_cnt;
    logic [CNT_W-1:0] r_pix_cnt;
    logic [POS_W-1:0] r_pix_pos, n_pix_pos;
    logic [CNT_W-1:0] r_ch_done, n_ch_done;

    logic [CNT_W-1:0] chans_eff, pix_eff, remaining;
    logic [pcca_pkg::LUSED_W-1:0] lanes_used;
    logic [LN_W-1:0]  lanes_cap, lanes_eff;
    logic             final_grp, group_end;
    pcca_pkg::t_item_ctl in_ctl;

    // pipeline
    logic                s1_ready, s2_ready, s2_adv, out_free, in_acc;
    logic                r_s1_vld, r_s2_vld;
    pcca_pkg::t_item_ctl r_s1_ctl, r_s2_ctl;
    pcca_pkg::t_prod     products [LANES];
    pcca_pkg::t_sum      s2_sum;
    logic [ACC_W-1:0]    ram_rdata;
    pcca_pkg::t_acc      s1_old, r_s2_old, s2_old, s2_acc;
    pcca_pkg::t_acc_ext  s2_raw;
    logic signed [OUT_W-1:0] s2_out;

    // last write-back, for forwarding
    logic                r_wr_vld;
    logic [AW-1:0]       r_wr_idx;
    pcca_pkg::t_acc      r_wr_val;

    // output register
    logic                r_o_vld;
    logic [POS_W-1:0]    r_o_pix;
    logic signed [OUT_W-1:0] r_o_val;
    logic                r_o_last;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt <= CNT_W'(1);
            r_pix_cnt  <= CNT_W'(1);
        end else if (i_cfg_valid) begin
            case (pcca_pkg::t_cfg_idx'(i_cfg_index))
                pcca_pkg::CFG_CHANNEL_COUNT: r_chan_cnt <= i_cfg_data;
                pcca_pkg::CFG_PIXEL_COUNT:   r_pix_cnt  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective counts and the item's place in the plane
    always_comb begin
        chans_eff = (r_chan_cnt == '0) ? CNT_W'(1) : r_chan_cnt;
        if (r_pix_cnt == '0) begin
            pix_eff = CNT_W'(1);
        end else if (32'(r_pix_cnt) > pcca_pkg::MAX_PIXELS) begin
            pix_eff = CNT_W'(pcca_pkg::MAX_PIXELS);
        end else begin
            pix_eff = r_pix_cnt;
        end

        lanes_used = s_axis_tdata[2*LANES*SW +: pcca_pkg::LUSED_W];
        lanes_cap  = (32'(lanes_used) > LANES) ? LN_W'(LANES) : LN_W'(lanes_used);
        remaining  = (r_ch_done < chans_eff) ? (chans_eff - r_ch_done) : '0;
        lanes_eff  = (CNT_W'(lanes_cap) > remaining) ? LN_W'(remaining) : lanes_cap;

        final_grp = ({1'b0, r_ch_done} + (CNT_W + 1)'(lanes_eff)) >= {1'b0, chans_eff};
        group_end = ({1'b0, r_pix_pos} + (POS_W + 1)'(1)) >= (POS_W + 1)'(pix_eff);

        in_ctl.idx       = AW'(r_pix_pos);
        in_ctl.pos       = r_pix_pos;
        in_ctl.first_grp = (r_ch_done == '0);
        in_ctl.final_grp = final_grp;
        in_ctl.last_pix  = group_end;

        if (group_end) begin
            n_pix_pos = '0;
            n_ch_done = final_grp ? '0 : (r_ch_done + CNT_W'(lanes_eff));
        end else begin
            n_pix_pos = r_pix_pos + POS_W'(1);
            n_ch_done = r_ch_done;
        end
    end

    // stage handshakes
    assign out_free      = !r_o_vld || m_axis_tready;
    assign s2_adv        = r_s2_vld && (!r_s2_ctl.final_grp || out_free);
    assign s2_ready      = !r_s2_vld || s2_adv;
    assign s1_ready      = !r_s1_vld || s2_ready;
    assign s_axis_tready = s1_ready;
    assign in_acc        = s_axis_tvalid && s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_pos <= '0;
            r_ch_done <= '0;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_wr_vld  <= 1'b0;
            r_o_vld   <= 1'b0;
        end else begin
            if (in_acc) begin
                r_pix_pos <= n_pix_pos;
                r_ch_done <= n_ch_done;
            end
            if (s1_ready) begin
                r_s1_vld <= in_acc;
            end
            if (s2_ready) begin
                r_s2_vld <= r_s1_vld;
            end
            if (s2_adv) begin
                r_wr_vld <= 1'b1;
            end
            if (s2_adv && r_s2_ctl.final_grp) begin
                r_o_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // multiply lanes
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        pcca_lane u_lane (
            .i_clk     (i_clk),
            .i_en      (s1_ready),
            .i_lane_on (LN_W'(k) < lanes_eff),
            .i_sample  (pcca_pkg::t_sample'(s_axis_tdata[k*SW +: SW])),
            .i_weight  (pcca_pkg::t_sample'(s_axis_tdata[(LANES + k)*SW +: SW])),
            .o_product (products[k])
        );
    end

    pcca_merge u_merge (
        .i_clk      (i_clk),
        .i_en       (s2_ready),
        .i_products (products),
        .o_sum      (s2_sum)
    );

    pcca_ram #(
        .WIDTH (ACC_W),
        .DEPTH (pcca_pkg::MAX_PIXELS)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (s2_adv),
        .i_waddr (r_s2_ctl.idx),
        .i_wdata (s2_acc),
        .i_re    (in_acc),
        .i_raddr (in_ctl.idx),
        .o_rdata (ram_rdata)
    );

    // forward a write that landed on the read edge
    assign s1_old = (r_wr_vld && r_wr_idx == r_s1_ctl.idx) ? r_wr_val
                                                          : pcca_pkg::t_acc'(ram_rdata);

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_ctl <= in_ctl;
        end
        if (s2_ready) begin
            r_s2_ctl <= r_s1_ctl;
            r_s2_old <= s1_old;
        end
        if (s2_adv) begin
            r_wr_idx <= r_s2_ctl.idx;
            r_wr_val <= s2_acc;
        end
        if (s2_adv && r_s2_ctl.final_grp) begin
            r_o_pix  <= r_s2_ctl.pos;
            r_o_val  <= s2_out;
            r_o_last <= r_s2_ctl.last_pix;
        end
    end

    // accumulate and saturate
    always_comb begin
        s2_old = (r_wr_vld && r_wr_idx == r_s2_ctl.idx) ? r_wr_val : r_s2_old;
        if (r_s2_ctl.first_grp) begin
            s2_raw = pcca_pkg::t_acc_ext'(s2_sum);
        end else begin
            s2_raw = pcca_pkg::t_acc_ext'(s2_old) + pcca_pkg::t_acc_ext'(s2_sum);
        end

        if (s2_raw[ACC_W] != s2_raw[ACC_W-1]) begin
            s2_acc = s2_raw[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            s2_acc = s2_raw[ACC_W-1:0];
        end

        if (s2_acc[ACC_W-1:OUT_W-1] == '0 || s2_acc[ACC_W-1:OUT_W-1] == '1) begin
            s2_out = s2_acc[OUT_W-1:0];
        end else begin
            s2_out = s2_acc[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = pcca_pkg::OUT_DATA_W'({r_o_val, r_o_pix});

`ifndef SYNTHESIS
    a_final_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_adv && r_s2_ctl.final_grp |=> m_axis_tvalid)
        else $error("finished pixel did not reach the output register");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s2_ready |=> r_s1_vld && $stable(r_s1_ctl))
        else $error("stage 1 item lost while stage 2 stalled");

    a_accept_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_vld)
        else $error("accepted item missing from stage 1");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_s2_vld |-> !s2_adv)
        else $error("accumulator write without a stage 2 item");
`endif

endmodule
